// File: sv/rnc_pkg.sv
package rnc_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned MAX_DIMS_DEF   = 8;
    localparam int unsigned COORD_BITS_DEF = 16;

    // Fixed field widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned RADIUS_W = 19;
    localparam int unsigned LIMIT_W  = 11;
    localparam int unsigned DIMS_W   = 4;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 19;
    localparam int unsigned COORD_PORTS = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [DIMS_W-1:0]  DIMS_RST     = 4'd8;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // Register indices
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

endpackage

// File: sv/radius_neighbor_count.sv
// Channel   | Ports                                  | Direction
// ----------+----------------------------------------+----------
// request   | s_valid/s_ready, s_action, s_coord_*,  | in
//           | s_batch_end                            |
// result    | m_valid/m_ready, m_neighbor_count,     | out
//           | m_status, m_batch_done                 |
// config    | cfg_valid/cfg_ready, cfg_index,        | in
//           | cfg_data                               |
//
// Append, clear, unused actions and a query on an empty store raise the
// result from the DONE state into the result register, with no scan.
// A query scans every stored point: the point memory has one read
// port and delivers one stored point per cycle, followed by a
// square/sum/compare pipeline.
// One request in flight at a time; the result register frees the input
// side once a result is handed over. A stalled result holds the block.
// Reset clears the point count and registers; the memory needs no clearing.
module radius_neighbor_count #(
    parameter int unsigned MAX_POINTS = rnc_pkg::MAX_POINTS_DEF,
    parameter int unsigned MAX_DIMS   = rnc_pkg::MAX_DIMS_DEF,
    parameter int unsigned COORD_BITS = rnc_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rnc_pkg::ACTION_W-1:0]        s_action,
    input  logic signed [COORD_BITS-1:0]        s_coord_0,
    input  logic signed [COORD_BITS-1:0]        s_coord_1,
    input  logic signed [COORD_BITS-1:0]        s_coord_2,
    input  logic signed [COORD_BITS-1:0]        s_coord_3,
    input  logic signed [COORD_BITS-1:0]        s_coord_4,
    input  logic signed [COORD_BITS-1:0]        s_coord_5,
    input  logic signed [COORD_BITS-1:0]        s_coord_6,
    input  logic signed [COORD_BITS-1:0]        s_coord_7,
    input  logic                                s_batch_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rnc_pkg::COUNT_W-1:0]         m_neighbor_count,
    output logic                                m_status,
    output logic                                m_batch_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rnc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rnc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned PW     = $clog2(MAX_POINTS + 1);
    localparam int unsigned ROW_W  = MAX_DIMS * COORD_BITS;
    localparam int unsigned SQ_W   = 2 * COORD_BITS + 2;
    localparam int unsigned SUM_W  = SQ_W + 3;
    localparam int unsigned R2_W   = 2 * rnc_pkg::RADIUS_W;
    localparam int unsigned CMP_W  = (SUM_W > R2_W) ? SUM_W : R2_W;

    // Configuration registers
    logic [rnc_pkg::RADIUS_W-1:0] radius_reg;
    logic [rnc_pkg::LIMIT_W-1:0]  limit_reg;
    logic [rnc_pkg::DIMS_W-1:0]   dims_reg;

    // Point memory: one row per point, all coordinates side by side
    logic [ROW_W-1:0] point_mem [MAX_POINTS];
    logic [ROW_W-1:0] rd_row_reg;

    rnc_pkg::state_t state_reg, state_next;

    logic [PW-1:0]                 stored_reg;
    logic [PW-1:0]                 idx_reg, idx_next;
    logic [rnc_pkg::ACTION_W-1:0]  action_reg;
    logic                          batch_reg;
    logic                          status_reg, status_next;
    logic [COORD_BITS-1:0]         query_reg [MAX_DIMS];
    logic [MAX_DIMS-1:0]           lane_en_reg;
    logic [R2_W-1:0]               r2_reg;

    logic                          v1_reg, v2_reg, v3_reg;
    logic [SQ_W-1:0]               sq_reg [MAX_DIMS];
    logic [SUM_W-1:0]              sum_reg;
    logic [rnc_pkg::COUNT_W-1:0]   count_reg;

    logic                          m_valid_reg;
    logic [rnc_pkg::COUNT_W-1:0]   m_count_reg;
    logic                          m_status_reg;
    logic                          m_batch_reg;

    logic [COORD_BITS-1:0]         coord_in [rnc_pkg::COORD_PORTS];
    logic                          s_fire;
    logic                          rd_en;
    logic                          out_load;
    logic                          full;
    logic [rnc_pkg::DIMS_W-1:0]    dims_eff;

    assign coord_in[0] = s_coord_0;
    assign coord_in[1] = s_coord_1;
    assign coord_in[2] = s_coord_2;
    assign coord_in[3] = s_coord_3;
    assign coord_in[4] = s_coord_4;
    assign coord_in[5] = s_coord_5;
    assign coord_in[6] = s_coord_6;
    assign coord_in[7] = s_coord_7;

    assign s_ready   = (state_reg == rnc_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign full      = (stored_reg == PW'(MAX_POINTS));
    assign dims_eff  = (dims_reg > rnc_pkg::DIMS_W'(MAX_DIMS))
                       ? rnc_pkg::DIMS_W'(MAX_DIMS) : dims_reg;

    // Configuration writes; an index beyond the list is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            limit_reg  <= '0;
            dims_reg   <= rnc_pkg::DIMS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rnc_pkg::REG_RADIUS: radius_reg <= cfg_data;
                rnc_pkg::REG_LIMIT:  limit_reg  <= cfg_data[rnc_pkg::LIMIT_W-1:0];
                rnc_pkg::REG_DIMS:   dims_reg   <= cfg_data[rnc_pkg::DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rnc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            rnc_pkg::ST_IDLE: begin
                idx_next = '0;
                if (s_fire) begin
                    status_next = (s_action == rnc_pkg::ACT_APPEND) && full;
                    if (s_action == rnc_pkg::ACT_QUERY && stored_reg != '0) begin
                        state_next = rnc_pkg::ST_SCAN;
                    end else begin
                        state_next = rnc_pkg::ST_DONE;
                    end
                end
            end
            rnc_pkg::ST_SCAN: begin
                rd_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == stored_reg - 1'b1) begin
                    state_next = rnc_pkg::ST_FLUSH;
                end
            end
            rnc_pkg::ST_FLUSH: begin
                if (!v1_reg && !v2_reg && !v3_reg) begin
                    state_next = rnc_pkg::ST_DONE;
                end
            end
            rnc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = rnc_pkg::ST_IDLE;
                end
            end
            default: state_next = rnc_pkg::ST_IDLE;
        endcase
    end

    // Request capture and point count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg <= '0;
            idx_reg    <= '0;
            status_reg <= 1'b0;
        end else begin
            idx_reg    <= idx_next;
            status_reg <= status_next;
            if (s_fire) begin
                if (s_action == rnc_pkg::ACT_APPEND && !full) begin
                    stored_reg <= stored_reg + 1'b1;
                end else if (s_action == rnc_pkg::ACT_CLEAR) begin
                    stored_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            action_reg <= s_action;
            batch_reg  <= s_batch_end;
            r2_reg     <= R2_W'(radius_reg) * R2_W'(radius_reg);
            for (int k = 0; k < MAX_DIMS; k++) begin
                query_reg[k]   <= coord_in[k];
                lane_en_reg[k] <= (k < int'(dims_eff));
            end
        end
    end

    // Point memory: append writes at the fill count, the scan reads in order
    always_ff @(posedge aclk) begin
        if (s_fire && s_action == rnc_pkg::ACT_APPEND && !full) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                point_mem[stored_reg[AW-1:0]][k*COORD_BITS +: COORD_BITS] <= coord_in[k];
            end
        end
        if (rd_en) begin
            rd_row_reg <= point_mem[idx_reg[AW-1:0]];
        end
    end

    // Distance pipeline: square per lane, then sum, then compare and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            logic signed [COORD_BITS:0]  diff;
            logic signed [SQ_W-1:0]      sq;
            diff = $signed({rd_row_reg[k*COORD_BITS + COORD_BITS - 1],
                            rd_row_reg[k*COORD_BITS +: COORD_BITS]})
                 - $signed({query_reg[k][COORD_BITS-1], query_reg[k]});
            sq   = diff * diff;
            sq_reg[k] <= lane_en_reg[k] ? sq : '0;
        end
    end

    always_ff @(posedge aclk) begin
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            acc = acc + SUM_W'(sq_reg[k]);
        end
        sum_reg <= acc;
    end

    // Counting halts at a nonzero limit, or at the count ceiling
    always_ff @(posedge aclk) begin
        if (state_reg == rnc_pkg::ST_IDLE) begin
            count_reg <= '0;
        end else if (v3_reg && (CMP_W'(sum_reg) < CMP_W'(r2_reg))
                     && count_reg != rnc_pkg::COUNT_MAX
                     && (limit_reg == '0 || count_reg < limit_reg)) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_count_reg  <= (action_reg == rnc_pkg::ACT_QUERY) ? count_reg : '0;
            m_status_reg <= status_reg;
            m_batch_reg  <= batch_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_neighbor_count = m_count_reg;
    assign m_status         = m_status_reg;
    assign m_batch_done     = m_batch_reg;

endmodule

// File: sv/rnc_checker.sv
module rnc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [rnc_pkg::COUNT_W-1:0]    m_neighbor_count,
    input logic                           m_status
);

    // A dropped append never carries a count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_neighbor_count == '0)
        else $error("dropped append with nonzero count");

    // One request in flight: acceptance closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // No result appears in the cycle after acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_neighbor_count))
        else $error("stalled result changed");

endmodule

bind radius_neighbor_count rnc_checker u_rnc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_neighbor_count (m_neighbor_count),
    .m_status         (m_status)
);

// File: tb/sv/tb_radius_neighbor_count.sv
module tb_radius_neighbor_count;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS  = rnc_pkg::MAX_POINTS_DEF;
    localparam int NDIMS = rnc_pkg::MAX_DIMS_DEF;
    localparam int CW    = rnc_pkg::COORD_BITS_DEF;
    // slowest run: ~600 queries at a full store, long stalls, big gaps; taken
    // several times over
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam logic [rnc_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef logic [NDIMS-1:0][CW-1:0] point_t;

    typedef struct packed {
        logic [rnc_pkg::COUNT_W-1:0] neighbours;
        logic                        dropped;
        logic                        batch_done;
    } answer_t;

    logic aclk;
    logic aresetn;

    // request side
    logic                         s_valid;
    logic                         s_ready;
    logic [rnc_pkg::ACTION_W-1:0] s_action;
    point_t                       s_pt;
    logic                         s_batch_end;

    // result side
    logic                        m_valid;
    logic                        m_ready;
    logic [rnc_pkg::COUNT_W-1:0] m_neighbor_count;
    logic                        m_status;
    logic                        m_batch_done;

    // register writes
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rnc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rnc_pkg::CFG_DATA_W-1:0] cfg_data;

    radius_neighbor_count u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_coord_0        (s_pt[0]),
        .s_coord_1        (s_pt[1]),
        .s_coord_2        (s_pt[2]),
        .s_coord_3        (s_pt[3]),
        .s_coord_4        (s_pt[4]),
        .s_coord_5        (s_pt[5]),
        .s_coord_6        (s_pt[6]),
        .s_coord_7        (s_pt[7]),
        .s_batch_end      (s_batch_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_count (m_neighbor_count),
        .m_status         (m_status),
        .m_batch_done     (m_batch_done),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ---- own copy of block state ----
    point_t                       ref_points [NPTS];
    int                           n_points;
    logic [rnc_pkg::RADIUS_W-1:0] cur_radius;
    logic [rnc_pkg::LIMIT_W-1:0]  cur_limit;
    logic [rnc_pkg::DIMS_W-1:0]   cur_dims;

    answer_t pending_answers [$];
    int      mismatches;
    longint  cycles;

    // receiver control: idle_on enables random stalls, hold_req asks for
    // one long hold-off, counted down in the receiver process itself
    bit idle_on;
    int hold_req;
    int stall_left;
    // sender gap enable
    bit gaps_on;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // count of stored points strictly inside the radius, capped at the limit
    function automatic logic [rnc_pkg::COUNT_W-1:0] count_within_radius(point_t q);
        longint unsigned r2;
        longint unsigned dsq;
        longint          diff;
        int              nd;
        int              hits;
        r2   = longint'(cur_radius) * longint'(cur_radius);
        nd   = (cur_dims > NDIMS) ? NDIMS : int'(cur_dims);
        hits = 0;
        for (int i = 0; i < n_points; i++) begin
            if (cur_limit != 0 && hits >= cur_limit) break;
            dsq = 0;
            for (int k = 0; k < nd; k++) begin
                diff = longint'($signed(ref_points[i][k])) - longint'($signed(q[k]));
                dsq += longint'(diff * diff);
            end
            if (dsq < r2 && hits < int'(rnc_pkg::COUNT_MAX)) hits++;
        end
        return hits[rnc_pkg::COUNT_W-1:0];
    endfunction

    // update state for an accepted request and return what must come back
    function automatic answer_t apply_request(logic [rnc_pkg::ACTION_W-1:0] act,
                                              point_t p, logic be);
        answer_t a;
        a = '0;
        a.batch_done = be;
        case (act)
            rnc_pkg::ACT_APPEND: begin
                if (n_points >= NPTS) begin
                    a.dropped = 1'b1;
                end else begin
                    ref_points[n_points] = p;
                    n_points++;
                end
            end
            rnc_pkg::ACT_QUERY: a.neighbours = count_within_radius(p);
            rnc_pkg::ACT_CLEAR: n_points = 0;
            default: ;
        endcase
        return a;
    endfunction

    // ---- result checker ----
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: count %0d status %0b batch %0b",
                             m_neighbor_count, m_status, m_batch_done);
            end else begin
                want = pending_answers.pop_front();
                if (m_neighbor_count !== want.neighbours || m_status !== want.dropped ||
                    m_batch_done !== want.batch_done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: count %0d/%0d status %0b/%0b batch %0b/%0b",
                                 want.neighbours, m_neighbor_count, want.dropped,
                                 m_status, want.batch_done, m_batch_done);
                end
            end
        end
    end

    // ---- receiver stalls ----
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!idle_on || $urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            // mostly short stalls, now and then a long one
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 3);
        end
    end

    // ---- sender helpers; all called at a falling edge ----
    task automatic send_request(logic [rnc_pkg::ACTION_W-1:0] act, point_t p, logic be);
        int gap;
        s_valid     <= 1'b1;
        s_action    <= act;
        s_pt        <= p;
        s_batch_end <= be;
        do @(posedge aclk); while (!s_ready);
        pending_answers.push_back(apply_request(act, p, be));
        @(negedge aclk);
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 35)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [rnc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[rnc_pkg::CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rnc_pkg::REG_RADIUS: cur_radius = val[rnc_pkg::RADIUS_W-1:0];
            rnc_pkg::REG_LIMIT:  cur_limit  = val[rnc_pkg::LIMIT_W-1:0];
            rnc_pkg::REG_DIMS:   cur_dims   = val[rnc_pkg::DIMS_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(int unsigned rad, int unsigned lim, int unsigned nd);
        wait_drained();
        write_reg(rnc_pkg::REG_RADIUS, rad);
        write_reg(rnc_pkg::REG_LIMIT, lim);
        write_reg(rnc_pkg::REG_DIMS, nd);
    endtask

    function automatic point_t fill_point(logic [CW-1:0] v);
        point_t p;
        for (int k = 0; k < NDIMS; k++) p[k] = v;
        return p;
    endfunction

    // clustered points around the origin, or anything at all
    function automatic point_t rand_point(bit spread);
        point_t p;
        for (int k = 0; k < NDIMS; k++)
            p[k] = spread ? CW'($urandom) : CW'($urandom_range(0, 1000) - 500);
        return p;
    endfunction

    // ---- tests ----

    // reset values: radius zero so every query counts nothing
    task automatic test_reset_values();
        send_request(rnc_pkg::ACT_APPEND, fill_point('0), 1'b0);
        send_request(rnc_pkg::ACT_QUERY, fill_point('0), 1'b1);
    endtask

    // coordinate extremes, every action, unused code, dims 0 and above 8
    task automatic test_directed();
        set_config(524287, 0, 8);
        send_request(rnc_pkg::ACT_CLEAR, fill_point('0), 1'b0);
        send_request(rnc_pkg::ACT_APPEND, fill_point(16'h7FFF), 1'b0);
        send_request(rnc_pkg::ACT_APPEND, fill_point(16'h8000), 1'b1);
        send_request(rnc_pkg::ACT_APPEND, fill_point('0), 1'b0);
        send_request(rnc_pkg::ACT_QUERY, fill_point('0), 1'b1);
        send_request(rnc_pkg::ACT_QUERY, fill_point(16'h8000), 1'b0);
        send_request(rnc_pkg::ACT_QUERY, fill_point(16'h7FFF), 1'b1);
        send_request(ACT_UNUSED, fill_point(16'hFFFF), 1'b1);
        send_request(rnc_pkg::ACT_QUERY, fill_point(16'h5555), 1'b0);
        // every point at distance zero when no coordinate is used
        set_config(1, 1, 0);
        send_request(rnc_pkg::ACT_QUERY, fill_point(16'h1234), 1'b1);
        set_config(1, 0, 0);
        send_request(rnc_pkg::ACT_QUERY, fill_point(16'hAAAA), 1'b0);
        // dims above the maximum act as the maximum
        set_config(65536, 2047, 15);
        send_request(rnc_pkg::ACT_QUERY, fill_point('0), 1'b0);
        set_config(0, 0, 1);
        send_request(rnc_pkg::ACT_QUERY, fill_point('0), 1'b1);
        send_request(rnc_pkg::ACT_CLEAR, fill_point('0), 1'b1);
        send_request(rnc_pkg::ACT_QUERY, fill_point('0), 1'b0);
    endtask

    // a run of appends, one far point, then queries under several settings
    task automatic test_many_points();
        set_config(300, 0, 2);
        send_request(rnc_pkg::ACT_CLEAR, fill_point('0), 1'b0);
        for (int i = 0; i < 40; i++)
            send_request(rnc_pkg::ACT_APPEND, rand_point(1'b0), i[0]);
        send_request(rnc_pkg::ACT_APPEND, rand_point(1'b1), 1'b1);
        send_request(rnc_pkg::ACT_QUERY, rand_point(1'b0), 1'b0);
        set_config(524287, 1024, 8);
        send_request(rnc_pkg::ACT_QUERY, rand_point(1'b0), 1'b1);
        set_config(700, 2047, 3);
        send_request(rnc_pkg::ACT_QUERY, rand_point(1'b0), 1'b0);
        send_request(rnc_pkg::ACT_CLEAR, fill_point('0), 1'b0);
    endtask

    // long receiver stall as requests come, a full pause, then back to back
    task automatic test_backpressure();
        set_config(400, 0, 8);
        hold_req = 300;
        for (int i = 0; i < 12; i++)
            send_request(i % 3 == 2 ? rnc_pkg::ACT_QUERY : rnc_pkg::ACT_APPEND,
                         rand_point(1'b0), 1'b0);
        wait_drained();
        // back to back with neither side idling
        idle_on = 1'b0;
        gaps_on = 1'b0;
        for (int i = 0; i < 16; i++)
            send_request(i[0] ? rnc_pkg::ACT_QUERY : rnc_pkg::ACT_APPEND,
                         rand_point(1'b0), i[1]);
        wait_drained();
        idle_on = 1'b1;
        gaps_on = 1'b1;
    endtask

    task automatic random_phase(int n, int unsigned rad, int unsigned lim,
                                int unsigned nd);
        int unsigned roll;
        logic [rnc_pkg::ACTION_W-1:0] act;
        set_config(rad, lim, nd);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      act = rnc_pkg::ACT_APPEND;
            else if (roll < 85) act = rnc_pkg::ACT_QUERY;
            else if (roll < 93) act = rnc_pkg::ACT_CLEAR;
            else                act = ACT_UNUSED;
            // mostly clustered points so that counts vary; some noise
            send_request(act, rand_point($urandom_range(0, 9) < 2), 1'($urandom));
        end
    endtask

    task automatic test_random();
        random_phase(80, 600, 0, 8);
        random_phase(80, 250, 3, 2);
        random_phase(80, 524287, 0, 8);
        random_phase(80, 900, 1, 4);
        random_phase(80, 150, 2047, 1);
        random_phase(80, $urandom_range(1, 2000), $urandom_range(0, 10),
                     $urandom_range(0, 15));
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_action    = rnc_pkg::ACT_APPEND;
        s_pt        = '0;
        s_batch_end = 1'b0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = rnc_pkg::REG_RADIUS;
        cfg_data    = '0;
        mismatches  = 0;
        cycles      = 0;
        idle_on     = 1'b1;
        gaps_on     = 1'b1;
        hold_req    = 0;
        stall_left  = 0;
        n_points    = 0;
        cur_radius  = '0;
        cur_limit   = '0;
        cur_dims    = rnc_pkg::DIMS_RST;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_directed();
        test_many_points();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/rnc_pkg.sv
sv/radius_neighbor_count.sv
sv/rnc_checker.sv
tb/sv/tb_radius_neighbor_count.sv
